// ----- rtl/bff_pkg.sv -----
// Shared constants, types and helper functions of the five-hash Bloom filter.
package bff_pkg;

  localparam int unsigned HASH_W     = 32;
  localparam int unsigned DIV_STEPS  = 4;
  localparam int unsigned DIV_CYCLES = HASH_W / DIV_STEPS;
  localparam int unsigned CNT_W      = $clog2(DIV_CYCLES);
  localparam int unsigned NUM_HASH   = 5;
  localparam int unsigned HIDX_W     = $clog2(NUM_HASH);
  localparam int unsigned FSIZE_W    = 21;

  localparam logic [HASH_W-1:0] HA_INIT = 32'd3;
  localparam logic [HASH_W-1:0] HB_INIT = 32'd17;
  localparam logic [HASH_W-1:0] HC_INIT = 32'd1153;
  localparam logic [HASH_W-1:0] HD_INIT = 32'd16659;
  localparam logic [HASH_W-1:0] HE_INIT = 32'd57;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic REG_FILTER_SIZE = 1'b0;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CALC  = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_MEM   = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  // Two's complement magnitude; the most negative value maps to 2^31.
  function automatic logic [HASH_W-1:0] mag32(input logic [HASH_W-1:0] x);
    mag32 = x[HASH_W-1] ? (~x + 32'd1) : x;
  endfunction

  // Remainder by 23 of a byte magnitude (at most 128).
  function automatic logic [4:0] mod23(input logic [7:0] a);
    logic [7:0] t;
    t = a;
    if (t >= 8'd115) t = t - 8'd115;
    if (t >= 8'd69)  t = t - 8'd69;
    if (t >= 8'd46)  t = t - 8'd46;
    if (t >= 8'd23)  t = t - 8'd23;
    mod23 = t[4:0];
  endfunction

endpackage

// ----- rtl/bff_mod.sv -----
// Iterative remainder unit: 32-bit dividend by the filter size, four bits a cycle.
module bff_mod #(
  parameter int unsigned RW = 21
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [bff_pkg::HASH_W-1:0]   dividend,
  input  logic [RW-1:0]                divisor,
  output logic                         done,
  output logic [RW-1:0]                remainder
);
  import bff_pkg::*;

  logic [HASH_W-1:0] quo;
  logic [RW-1:0]     rem;
  logic [RW-1:0]     rem_next;
  logic [CNT_W-1:0]  cnt;
  logic              busy;

  always_comb begin
    logic [RW:0] t2;
    rem_next = rem;
    for (int i = 0; i < int'(DIV_STEPS); i++) begin
      t2 = {rem_next, quo[HASH_W-1-i]};
      if (t2 >= {1'b0, divisor}) t2 = t2 - {1'b0, divisor};
      rem_next = t2[RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_CYCLES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= quo << DIV_STEPS;
      rem <= rem_next;
    end
  end

  assign remainder = rem;

endmodule

// ----- rtl/bff_store.sv -----
// Single-port bit store with a clearing pass after reset.
module bff_store #(
  parameter int unsigned DEPTH = 1048576,
  parameter int unsigned AW    = 20
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          wr,
  input  logic [AW-1:0] addr,
  output logic          rdata,
  output logic          clearing
);
  logic          mem [DEPTH];
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(DEPTH - 1)) clearing <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= 1'b0;
    end else if (en && wr) begin
      mem[addr] <= 1'b1;
    end else if (en) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- rtl/bloom_filter_five_hash.sv -----
// Top level of the five-hash Bloom filter: hash datapath, control and ports.
//
//  channel | signals                         | meaning
//  s_*     | tvalid tready tdata tuser tlast | one key byte a beat
//  m_*     | tvalid tready tdata             | lookup result
//  apb     | psel penable pwrite paddr ...   | filter_size at address 0
//
// After its beat a byte keeps the block busy: hc is squared as the beat is taken,
// ST_CALC forms the dividends, the remainder units run in ST_DIV (four quotient
// bits a cycle) and the hashes are registered; the next beat waits for ST_IDLE.
// A final byte adds five store accesses on the single memory port; a lookup then
// passes ST_DRAIN, ST_OUT. After reset all MAX_BITS bits are swept clear, one a cycle;
// s_tready stays low meanwhile. A lookup whose result finds the previous one still
// waiting on m_tready holds in its last state, and s_tready stays low until it leaves.
module bloom_filter_five_hash #(
  parameter int unsigned MAX_BITS = 1048576
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_byte
  input  logic        s_tuser,   // [0] operation
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [0] member, [7:1] zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bff_pkg::*;

  localparam int unsigned AW = $clog2(MAX_BITS);
  localparam int unsigned RW = AW + 1;

  state_t state;

  logic [FSIZE_W-1:0] filter_size;
  logic [RW-1:0]      n_eff;
  logic [RW-1:0]      n_q;

  logic [HASH_W-1:0]  ha, hb, hc, hd, he;
  logic [HASH_W-1:0]  sq, hc_pend;
  logic [7:0]         a_q;
  logic               op_q, last_q;

  logic [HASH_W-1:0]  div_in  [NUM_HASH];
  logic [RW-1:0]      div_rem [NUM_HASH];
  logic [NUM_HASH-1:0] div_done;
  logic               div_start;

  logic [AW-1:0]      idx [NUM_HASH];
  logic [HIDX_W-1:0]  k;
  logic               acc, rvalid;
  logic               mem_en, mem_rdata, clearing;
  logic [7:0]         a_mag;
  logic               out_free;

  // Configuration port.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_size <= FSIZE_W'(MAX_BITS);
    end else if (psel && penable && pwrite && paddr[2] == REG_FILTER_SIZE) begin
      filter_size <= pwdata[FSIZE_W-1:0];
    end
  end
  assign prdata = (paddr[2] == REG_FILTER_SIZE) ? 32'(filter_size) : 32'd0;

  always_comb begin
    if (filter_size == '0) n_eff = RW'(1);
    else if (32'(filter_size) > 32'(MAX_BITS)) n_eff = RW'(MAX_BITS);
    else n_eff = RW'(filter_size);
  end

  assign a_mag    = s_tdata[7] ? (8'd0 - s_tdata) : s_tdata;
  assign s_tready = (state == ST_IDLE) && !clearing;
  assign out_free = !m_tvalid || m_tready;

  // Dividends of the five remainder units, from the registered byte.
  always_comb begin
    div_in[0] = (ha << 5) - ha + 32'(a_q);
    div_in[1] = hb + 32'(mod23(a_q));
    div_in[2] = mag32(sq + 32'(a_q));
    div_in[3] = (hd << 5) + hd + 32'(a_q);
    div_in[4] = mag32(32'(a_q) + (he << 6) + (he << 16) - he);
  end
  assign div_start = (state == ST_CALC);

  for (genvar g = 0; g < NUM_HASH; g++) begin : g_div
    bff_mod #(.RW(RW)) u_mod (
      .clk       (clk),
      .rst       (rst),
      .start     (div_start),
      .dividend  (div_in[g]),
      .divisor   (n_q),
      .done      (div_done[g]),
      .remainder (div_rem[g])
    );
  end

  assign mem_en = (state == ST_MEM);

  bff_store #(.DEPTH(MAX_BITS), .AW(AW)) u_store (
    .clk      (clk),
    .rst      (rst),
    .en       (mem_en),
    .wr       (op_q == OP_INSERT),
    .addr     (idx[k]),
    .rdata    (mem_rdata),
    .clearing (clearing)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      rvalid   <= 1'b0;
      k        <= '0;
      ha <= HA_INIT;
      hb <= HB_INIT;
      hc <= HC_INIT;
      hd <= HD_INIT;
      he <= HE_INIT;
    end else begin
      rvalid <= mem_en && (op_q == OP_LOOKUP);
      if (state == ST_OUT && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_tvalid && s_tready) state <= ST_CALC;
        end
        ST_CALC: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done[0]) begin
            if (last_q) begin
              ha <= HA_INIT;
              hb <= HB_INIT;
              hc <= HC_INIT;
              hd <= HD_INIT;
              he <= HE_INIT;
              k  <= '0;
              state <= ST_MEM;
            end else begin
              ha <= HASH_W'(div_rem[0]);
              hb <= HASH_W'(div_rem[1]);
              hc <= hc_pend;
              hd <= HASH_W'(div_rem[3]);
              he <= HASH_W'(div_rem[4]);
              state <= ST_IDLE;
            end
          end
        end
        ST_MEM: begin
          k <= k + 1'b1;
          if (k == HIDX_W'(NUM_HASH - 1)) begin
            state <= (op_q == OP_LOOKUP) ? ST_DRAIN : ST_IDLE;
          end
        end
        ST_DRAIN: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      a_q    <= a_mag;
      op_q   <= s_tuser;
      last_q <= s_tlast;
      n_q    <= n_eff;
      sq     <= hc * hc;
    end
    if (state == ST_CALC) hc_pend <= sq + 32'(a_q);
    if (state == ST_DIV && div_done[0]) begin
      for (int i = 0; i < int'(NUM_HASH); i++) idx[i] <= div_rem[i][AW-1:0];
    end
    if (state == ST_MEM && k == '0) acc <= 1'b1;
    else if (rvalid) acc <= acc & mem_rdata;
    if (state == ST_OUT && out_free) m_tdata <= {7'd0, acc};
  end

endmodule
